// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MKSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MKSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mksc_pkg.sv =====
// types and constants of the motion to key step converter
// no dependencies
package mksc_pkg;

  localparam int NUM_AXES = 5;
  localparam int MAX_TAPS = 64;

  typedef logic [2:0] axis_t;
  typedef logic [1:0] dir_t;
  typedef logic [1:0] mode_t;
  typedef logic [3:0] key_t;

  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_POS  = 2'd1;
  localparam dir_t DIR_NEG  = 2'd2;

  localparam mode_t MODE_ARROW = 2'd3;

  localparam axis_t AXIS_ARROW_X = 3'd3;
  localparam axis_t AXIS_ARROW_Y = 3'd4;

  localparam key_t KEY_ARROW_RIGHT = 4'd6;
  localparam key_t KEY_ARROW_DOWN  = 4'd8;
  localparam key_t KEY_MAX         = 4'd9;

  localparam logic [15:0] STEP_MIN = 16'd2;
  localparam logic [15:0] STEP_RESET [NUM_AXES] = '{16'd60, 16'd60, 16'd80, 16'd40, 16'd50};

  typedef struct packed {
    logic capture;
    logic prep;
    logic emit;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic can_emit;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/mksc_ctrl.sv =====
// controller of the motion to key step converter: idle, prepare, tap loop
// depends on mksc_pkg
module mksc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mksc_pkg::status_t st,
  output mksc_pkg::cmd_t    cmd
);
  import mksc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_TAP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   done;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    done      = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = st.is_clear ? ST_IDLE : ST_TAP;
      end
      ST_TAP: begin
        cmd.emit  = st.can_emit && st.out_free;
        done      = !st.can_emit || (cmd.emit && st.last);
        cmd.wb    = done;
        state_nxt = done ? ST_IDLE : ST_TAP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/mksc_dp.sv =====
// datapath: step registers, axis accumulators and directions, tap loop, output register
// depends on mksc_pkg
module mksc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic [1:0]        in_mode,
  input  logic signed [7:0] in_delta_x,
  input  logic signed [7:0] in_delta_y,
  input  logic              in_clear,
  input  mksc_pkg::cmd_t    cmd,
  output mksc_pkg::status_t st,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [3:0]        out_tap_key,
  output logic              out_last_tap
);
  import mksc_pkg::*;

  logic [15:0]        step_r [NUM_AXES];
  logic signed [17:0] acc_r  [NUM_AXES];
  dir_t               dir_r  [NUM_AXES];
  logic               hsel_r;

  mode_t              it_mode_r;
  logic signed [7:0]  it_dx_r, it_dy_r;
  logic               it_clear_r;

  logic signed [17:0] w_acc_r;
  logic [15:0]        w_thr_r;
  axis_t              w_axis_r;
  key_t               w_key_r;
  logic [5:0]         cnt_r;

  logic               out_valid_r, out_last_r;
  key_t               out_key_r;

  // prepare stage
  logic [7:0]         abs_x, abs_y;
  logic               arrow, hsel_nxt, nz;
  axis_t              sel_axis;
  logic signed [7:0]  sel_delta;
  key_t               sel_key;
  dir_t               new_dir;
  logic signed [17:0] base, acc_load;
  logic [15:0]        thr_load;

  // tap stage
  logic signed [17:0] thr_s, acc_step, acc_wb;
  logic               pos, neg;

  always_comb begin
    abs_x     = it_dx_r[7] ? (~it_dx_r + 8'd1) : it_dx_r;
    abs_y     = it_dy_r[7] ? (~it_dy_r + 8'd1) : it_dy_r;
    arrow     = (it_mode_r == MODE_ARROW);
    if (abs_x > abs_y) begin
      hsel_nxt = 1'b1;
    end else if (abs_y > abs_x) begin
      hsel_nxt = 1'b0;
    end else begin
      hsel_nxt = hsel_r;
    end
    if (arrow) begin
      sel_axis  = hsel_nxt ? AXIS_ARROW_X : AXIS_ARROW_Y;
      sel_delta = hsel_nxt ? it_dx_r : it_dy_r;
      sel_key   = hsel_nxt ? KEY_ARROW_RIGHT : KEY_ARROW_DOWN;
    end else begin
      sel_axis  = {1'b0, it_mode_r};
      sel_delta = it_dy_r;
      sel_key   = {1'b0, it_mode_r, 1'b0};
    end
    nz       = (sel_delta != 8'sd0);
    new_dir  = sel_delta[7] ? DIR_NEG : DIR_POS;
    base     = (nz && dir_r[sel_axis] != DIR_NONE && dir_r[sel_axis] != new_dir) ?
               18'sd0 : acc_r[sel_axis];
    acc_load = base + 18'(sel_delta);
    thr_load = (step_r[sel_axis] < STEP_MIN) ? STEP_MIN : step_r[sel_axis];
  end

  always_comb begin
    thr_s       = signed'({2'b00, w_thr_r});
    pos         = (w_acc_r >= thr_s);
    neg         = (w_acc_r <= -thr_s);
    acc_step    = pos ? (w_acc_r - thr_s) : (w_acc_r + thr_s);
    acc_wb      = cmd.emit ? acc_step : w_acc_r;
    st.is_clear = it_clear_r;
    st.can_emit = pos || neg;
    st.last     = (cnt_r == 6'(MAX_TAPS - 1)) || (acc_step < thr_s && acc_step > -thr_s);
    st.out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        step_r[i] <= STEP_RESET[i];
      end
    end else if (cfg_we && cfg_index < 3'(NUM_AXES)) begin
      step_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        acc_r[i] <= '0;
        dir_r[i] <= DIR_NONE;
      end
      hsel_r <= 1'b1;
    end else if (cmd.prep) begin
      if (it_clear_r) begin
        if (arrow) begin
          acc_r[AXIS_ARROW_X] <= '0;
          dir_r[AXIS_ARROW_X] <= DIR_NONE;
          acc_r[AXIS_ARROW_Y] <= '0;
          dir_r[AXIS_ARROW_Y] <= DIR_NONE;
          hsel_r              <= 1'b1;
        end else begin
          acc_r[sel_axis] <= '0;
          dir_r[sel_axis] <= DIR_NONE;
        end
      end else begin
        if (nz) begin
          dir_r[sel_axis] <= new_dir;
        end
        if (arrow) begin
          hsel_r <= hsel_nxt;
          // the idle arrow axis drops its state when it moves
          if (hsel_nxt && it_dy_r != 8'sd0) begin
            acc_r[AXIS_ARROW_Y] <= '0;
            dir_r[AXIS_ARROW_Y] <= DIR_NONE;
          end
          if (!hsel_nxt && it_dx_r != 8'sd0) begin
            acc_r[AXIS_ARROW_X] <= '0;
            dir_r[AXIS_ARROW_X] <= DIR_NONE;
          end
        end
      end
    end else if (cmd.wb) begin
      acc_r[w_axis_r] <= acc_wb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode_r  <= in_mode;
      it_dx_r    <= in_delta_x;
      it_dy_r    <= in_delta_y;
      it_clear_r <= in_clear;
    end
    if (cmd.prep) begin
      w_acc_r  <= acc_load;
      w_thr_r  <= thr_load;
      w_axis_r <= sel_axis;
      w_key_r  <= sel_key;
      cnt_r    <= '0;
    end else if (cmd.emit) begin
      w_acc_r <= acc_step;
      cnt_r   <= cnt_r + 6'd1;
    end
    if (cmd.emit) begin
      out_key_r  <= pos ? w_key_r : (w_key_r + 4'd1);
      out_last_r <= st.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tap_key  = out_key_r;
  assign out_last_tap = out_last_r;

endmodule

// ===== rtl/motion_to_key_step_converter_core.sv =====
// an accepted beat goes from the prepare state to the tap loop, which fills the output
// register; on clear the beat goes from prepare straight back to idle; each item gives
// up to 64 taps, one per cycle from the accumulator step loop, held back by out_stall
// the next input beat is taken while the last tap still waits in the output register
// reset: synchronous on rst_n low; steps back to defaults, accumulators and directions
// cleared, horizontal arrow axis selected, no output pending
module motion_to_key_step_converter_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic signed [7:0] in_delta_x,
  input  logic signed [7:0] in_delta_y,
  input  logic              in_clear,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_tap_key,
  output logic              out_last_tap
);
  import mksc_pkg::*;

  cmd_t    cmd;
  status_t st;

  mksc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mksc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_mode      (in_mode),
    .in_delta_x   (in_delta_x),
    .in_delta_y   (in_delta_y),
    .in_clear     (in_clear),
    .cmd          (cmd),
    .st           (st),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_tap_key  (out_tap_key),
    .out_last_tap (out_last_tap)
  );

endmodule

// ===== rtl/mksc_checker.sv =====
// port-level checks of the motion to key step converter, bound to the top level
// depends on mksc_pkg and assert_macros.svh
`include "assert_macros.svh"

module mksc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_tap_key,
  input logic       out_last_tap
);
  import mksc_pkg::*;

  `MKSC_ASSERT_ALWAYS(a_reset_clean, clk, !rst_n |=> !in_stall && !out_valid, "reset left block busy")
  `MKSC_ASSERT(a_busy_after_beat, clk, rst_n, in_valid && !in_stall |=> in_stall, "second beat taken during work")
  `MKSC_ASSERT(a_key_range, clk, rst_n, out_valid |-> out_tap_key <= KEY_MAX, "tap key out of range")
  `MKSC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_tap_key) && $stable(out_last_tap), "stalled tap changed")

endmodule

bind motion_to_key_step_converter_core mksc_checker u_mksc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_tap_key  (out_tap_key),
  .out_last_tap (out_last_tap)
);
